// ===== rtl/svm_pkg.sv =====
// Shared widths, constants, sector codes and the duty rounding function.
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DUTY_WIDTH  = 16;
    localparam int SECT_WIDTH  = 3;

    // A = alpha * 2^16, K = beta * round(2^16 / sqrt 3); both fit PROD_W signed
    localparam int PROD_W = COORD_WIDTH + 17;
    localparam int TIME_W = PROD_W + 1;
    localparam int SUM_W  = TIME_W + 2;
    localparam int A_SHIFT = 16;

    localparam logic signed [PROD_W-1:0] INV_SQRT3_Q16 = PROD_W'(37837);

    // twice 1.0 at the internal scale, the clamp ceiling
    localparam logic signed [SUM_W-1:0] DUTY_FULL  = SUM_W'(1) <<< (COORD_WIDTH + 16);
    localparam logic signed [SUM_W-1:0] DUTY_ROUND = SUM_W'(1) <<< COORD_WIDTH;
    localparam int DUTY_SHIFT = COORD_WIDTH + 1;

    typedef enum logic [SECT_WIDTH-1:0] {
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5,
        SECT_6 = 3'd6
    } t_sector;

    typedef struct packed {
        t_sector                   sector;
        logic signed [TIME_W-1:0]  tx;
        logic signed [TIME_W-1:0]  ty;
    } t_times;

    function automatic logic [DUTY_WIDTH-1:0] to_duty(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] u;
        if (v < 0) begin
            c = '0;
        end else if (v > DUTY_FULL) begin
            c = DUTY_FULL;
        end else begin
            c = v;
        end
        u = c + DUTY_ROUND;
        return DUTY_WIDTH'(u >>> DUTY_SHIFT);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/svm_if.sv =====
// Request channels: modulation vector in, phase duties and sector out.
`timescale 1ns / 1ps
`default_nettype none
interface svm_vec_if import svm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] alpha_in;
    logic signed [COORD_WIDTH-1:0] beta_in;

    modport source (output valid, output alpha_in, output beta_in, input ready);
    modport sink   (input valid, input alpha_in, input beta_in, output ready);
endinterface

interface svm_duty_if import svm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [DUTY_WIDTH-1:0] duty_a;
    logic [DUTY_WIDTH-1:0] duty_b;
    logic [DUTY_WIDTH-1:0] duty_c;
    logic [SECT_WIDTH-1:0] sector_out;

    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    output sector_out, input ready);
    modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                    input sector_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/space_vector_modulator.sv =====
// Space vector modulator: sector and three phase duties from an alpha-beta vector.
//
// Channels: i_vec takes one request of alpha_in and beta_in, signed Q1.15.
// o_duty returns one request per input: duty_a, duty_b, duty_c (0 to 32768,
// 32768 is full duty, clamped outside the hexagon) and sector_out (1 to 6).
// Four register stages lie between acceptance and o_duty.valid: scaling
// multiply, sector and active times, duty levels, clamp and rounding
// into the output register.
// Throughput: one request per cycle, sustained while o_duty.ready stays high.
// Reset clears the stage valid bits only; the pipeline comes out empty and
// i_vec.ready is high in the first cycle after reset.
// When the receiver holds o_duty.ready low the output request stays put and
// each stage keeps taking requests until it is full; bubbles close up, and
// i_vec.ready drops only once every stage holds a request.
`timescale 1ns / 1ps
`default_nettype none
module space_vector_modulator import svm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    svm_vec_if.sink    i_vec,
    svm_duty_if.source o_duty
);

    logic   times_valid;
    logic   times_ready;
    t_times times;

    svm_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (i_vec),
        .o_valid (times_valid),
        .o_times (times),
        .i_ready (times_ready)
    );

    svm_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (times_valid),
        .i_times (times),
        .o_ready (times_ready),
        .o_duty  (o_duty)
    );

endmodule
`default_nettype wire

// ===== rtl/svm_sector.sv =====
// Scaling multiply, sector decision and active-vector times (two stages).
`timescale 1ns / 1ps
`default_nettype none
module svm_sector import svm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    svm_vec_if.sink   i_vec,
    output logic      o_valid,
    output t_times    o_times,
    input  wire logic i_ready
);

    logic                     r_v1;
    logic signed [PROD_W-1:0] r_a;
    logic signed [PROD_W-1:0] r_k;
    logic                     r_aneg;
    logic                     r_bneg;
    logic                     r_v2;
    t_times                   r_times;

    logic                     en1;
    logic                     en2;
    logic signed [PROD_W-1:0] a_ext;
    logic signed [PROD_W-1:0] b_ext;
    logic signed [TIME_W-1:0] a_x;
    logic signed [TIME_W-1:0] k_x;
    logic signed [TIME_W-1:0] k2_x;
    t_sector                  sec;
    t_times                   n_times;

    assign en2         = !r_v2 || i_ready;
    assign en1         = !r_v1 || en2;
    assign i_vec.ready = en1;
    assign o_valid     = r_v2;
    assign o_times     = r_times;

    assign a_ext = PROD_W'(i_vec.alpha_in);
    assign b_ext = PROD_W'(i_vec.beta_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_vec.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_vec.valid) begin
            r_a    <= a_ext <<< A_SHIFT;
            r_k    <= b_ext * INV_SQRT3_Q16;
            r_aneg <= i_vec.alpha_in[COORD_WIDTH-1];
            r_bneg <= i_vec.beta_in[COORD_WIDTH-1];
        end
        if (en2 && r_v1) begin
            r_times <= n_times;
        end
    end

    always_comb begin
        a_x  = TIME_W'(r_a);
        k_x  = TIME_W'(r_k);
        k2_x = k_x <<< 1;
        if (!r_bneg) begin
            if (!r_aneg) begin
                sec = (k_x > a_x) ? SECT_2 : SECT_1;
            end else begin
                sec = (-k_x > a_x) ? SECT_3 : SECT_2;
            end
        end else begin
            if (!r_aneg) begin
                sec = (-k_x > a_x) ? SECT_5 : SECT_6;
            end else begin
                sec = (k_x > a_x) ? SECT_4 : SECT_5;
            end
        end
        n_times.sector = sec;
        unique case (sec)
            SECT_1: begin
                n_times.tx = a_x - k_x;
                n_times.ty = k2_x;
            end
            SECT_2: begin
                n_times.tx = k_x - a_x;
                n_times.ty = a_x + k_x;
            end
            SECT_3: begin
                n_times.tx = k2_x;
                n_times.ty = -a_x - k_x;
            end
            SECT_4: begin
                n_times.tx = -k2_x;
                n_times.ty = k_x - a_x;
            end
            SECT_5: begin
                n_times.tx = -a_x - k_x;
                n_times.ty = a_x - k_x;
            end
            default: begin
                n_times.tx = a_x + k_x;
                n_times.ty = -k2_x;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/svm_duty.sv =====
// Duty levels, phase ordering, clamp and rounding into the output register.
`timescale 1ns / 1ps
`default_nettype none
module svm_duty import svm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_times i_times,
    output logic       o_ready,
    svm_duty_if.source o_duty
);

    logic                    r_v3;
    logic signed [SUM_W-1:0] r_lo;
    logic signed [SUM_W-1:0] r_mid;
    logic signed [SUM_W-1:0] r_hi;
    t_sector                 r_sec3;
    logic                    r_v4;
    logic [DUTY_WIDTH-1:0]   r_duty_a;
    logic [DUTY_WIDTH-1:0]   r_duty_b;
    logic [DUTY_WIDTH-1:0]   r_duty_c;
    t_sector                 r_sec4;

    logic                    en3;
    logic                    en4;
    logic signed [SUM_W-1:0] tx_x;
    logic signed [SUM_W-1:0] ty_x;
    logic signed [SUM_W-1:0] lvl_a;
    logic signed [SUM_W-1:0] lvl_b;
    logic signed [SUM_W-1:0] lvl_c;

    assign en4     = !r_v4 || o_duty.ready;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;

    assign tx_x = SUM_W'(i_times.tx);
    assign ty_x = SUM_W'(i_times.ty);

    assign o_duty.valid      = r_v4;
    assign o_duty.duty_a     = r_duty_a;
    assign o_duty.duty_b     = r_duty_b;
    assign o_duty.duty_c     = r_duty_c;
    assign o_duty.sector_out = r_sec4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && i_valid) begin
            r_lo   <= DUTY_FULL - tx_x - ty_x;
            r_mid  <= DUTY_FULL + tx_x - ty_x;
            r_hi   <= DUTY_FULL + tx_x + ty_x;
            r_sec3 <= i_times.sector;
        end
        if (en4 && r_v3) begin
            r_duty_a <= to_duty(lvl_a);
            r_duty_b <= to_duty(lvl_b);
            r_duty_c <= to_duty(lvl_c);
            r_sec4   <= r_sec3;
        end
    end

    always_comb begin
        unique case (r_sec3)
            SECT_1: begin
                lvl_a = r_lo;
                lvl_b = r_mid;
                lvl_c = r_hi;
            end
            SECT_2: begin
                lvl_a = r_mid;
                lvl_b = r_lo;
                lvl_c = r_hi;
            end
            SECT_3: begin
                lvl_a = r_hi;
                lvl_b = r_lo;
                lvl_c = r_mid;
            end
            SECT_4: begin
                lvl_a = r_hi;
                lvl_b = r_mid;
                lvl_c = r_lo;
            end
            SECT_5: begin
                lvl_a = r_mid;
                lvl_b = r_hi;
                lvl_c = r_lo;
            end
            default: begin
                lvl_a = r_lo;
                lvl_b = r_hi;
                lvl_c = r_mid;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/svm_checker.sv =====
// Port-level checks for the modulator and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module svm_checker import svm_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [DUTY_WIDTH-1:0] i_duty_a,
    input wire logic [DUTY_WIDTH-1:0] i_duty_b,
    input wire logic [DUTY_WIDTH-1:0] i_duty_c,
    input wire logic [SECT_WIDTH-1:0] i_sector
);

    localparam logic [DUTY_WIDTH-1:0] DUTY_MAX = DUTY_WIDTH'(32768);

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sector >= SECT_1) && (i_sector <= SECT_6))
        else $error("sector out of range");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_duty_a <= DUTY_MAX) && (i_duty_b <= DUTY_MAX)
                        && (i_duty_c <= DUTY_MAX))
        else $error("duty above full scale");

    a_duty_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_sector == SECT_1)) |-> (i_duty_a <= i_duty_b)
                                                  && (i_duty_b <= i_duty_c))
        else $error("phase order wrong in first sector");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_sector)
                                          && $stable(i_duty_a))
        else $error("stalled request changed");

endmodule

bind space_vector_modulator svm_checker u_svm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_duty.valid),
    .i_out_ready (o_duty.ready),
    .i_duty_a    (o_duty.duty_a),
    .i_duty_b    (o_duty.duty_b),
    .i_duty_c    (o_duty.duty_c),
    .i_sector    (o_duty.sector_out)
);
`default_nettype wire
